[rtl/c1sc_pkg.sv]
// Shared types, constants and cipher step functions for the Crypto1 word core.
// No dependencies; used by every module of the block.
package c1sc_pkg;

    localparam int unsigned HALF_W     = 24;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KEY_W      = 48;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned STEP_IDX_W = $clog2(WORD_W);

    // Eight cipher steps are evaluated per clock; a word is WORD_CHUNKS chunks.
    localparam int unsigned STEPS_PER_CYCLE = 8;
    localparam int unsigned SUB_W           = $clog2(STEPS_PER_CYCLE);
    localparam int unsigned WORD_CHUNKS     = WORD_W / STEPS_PER_CYCLE;
    localparam int unsigned PHASE_W         = $clog2(WORD_CHUNKS);

    localparam int unsigned DEF_CMD_DEPTH = 2;
    localparam int unsigned DEF_RES_DEPTH = 2;

    // Action codes on the input port.
    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CRYPT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ROLLBACK = 2'd2;

    localparam logic [HALF_W-1:0] POLY_ODD  = 24'h29CE5C;
    localparam logic [HALF_W-1:0] POLY_EVEN = 24'h870804;
    localparam logic [31:0]       FILTER_OUT = 32'hEC57E80A;
    localparam logic [31:0]       NLF_T0 = 32'h000f22c0;
    localparam logic [31:0]       NLF_T1 = 32'h0006c9c0;
    localparam logic [31:0]       NLF_T2 = 32'h0003c8b0;
    localparam logic [31:0]       NLF_T3 = 32'h0001e458;
    localparam logic [31:0]       NLF_T4 = 32'h0000d938;

    // Step k uses word bit k ^ 24 (big-endian bytes, LSB first in each byte).
    localparam logic [STEP_IDX_W-1:0] BYTE_SWAP = 5'd24;

    // Decoded command, as the front hands it to the back.
    typedef struct packed {
        logic               load;
        logic               word_op;
        logic               back;
        logic [PHASE_W-1:0] last_phase;
        logic [WORD_W-1:0]  word;
        logic               fb;
        logic [KEY_W-1:0]   key;
    } cmd_t;

    typedef struct packed {
        logic [HALF_W-1:0] odd;
        logic [HALF_W-1:0] even;
    } halves_t;

    typedef struct packed {
        logic [HALF_W-1:0] odd;
        logic [HALF_W-1:0] even;
        logic [WORD_W-1:0] ks;
    } chunk_t;

    typedef struct packed {
        logic [WORD_W-1:0] ks;
        logic [KEY_W-1:0]  regv;
    } result_t;

    // Nonlinear filter over the low 20 bits of the odd half.
    function automatic logic nlf(input logic [HALF_W-1:0] x);
        logic [4:0]  f;
        logic [31:0] t;
        t    = NLF_T0 >> x[3:0];
        f[4] = t[4];
        t    = NLF_T1 >> x[7:4];
        f[3] = t[3];
        t    = NLF_T2 >> x[11:8];
        f[2] = t[2];
        t    = NLF_T3 >> x[15:12];
        f[1] = t[1];
        t    = NLF_T4 >> x[19:16];
        f[0] = t[0];
        t    = FILTER_OUT >> f;
        return t[0];
    endfunction

    function automatic halves_t key_to_halves(input logic [KEY_W-1:0] key);
        halves_t h;
        h.odd  = '0;
        h.even = '0;
        for (int i = 0; i < HALF_W; i++) begin
            h.odd[i ^ 3]  = key[2*i+1];
            h.even[i ^ 3] = key[2*i];
        end
        return h;
    endfunction

    function automatic logic [KEY_W-1:0] pack_reg(input logic [HALF_W-1:0] odd,
                                                  input logic [HALF_W-1:0] even);
        logic [KEY_W-1:0] v;
        v = '0;
        for (int i = 0; i < HALF_W; i++) begin
            v[2*i+1] = odd[i ^ 3];
            v[2*i]   = even[i ^ 3];
        end
        return v;
    endfunction

    // One clock's worth of cipher steps, forward or backward.
    function automatic chunk_t run_chunk(input logic [HALF_W-1:0]  odd_in,
                                         input logic [HALF_W-1:0]  even_in,
                                         input logic [WORD_W-1:0]  word,
                                         input logic               fb,
                                         input logic               back,
                                         input logic [PHASE_W-1:0] phase);
        chunk_t                c;
        logic [HALF_W-1:0]     o;
        logic [HALF_W-1:0]     e;
        logic [HALF_W-1:0]     e_sh;
        logic                  r;
        logic                  nb;
        logic [SUB_W-1:0]      j;
        logic [STEP_IDX_W-1:0] k;
        logic [STEP_IDX_W-1:0] pos;
        c.odd  = odd_in;
        c.even = even_in;
        c.ks   = '0;
        for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
            j = SUB_W'(i);
            if (back) begin
                // rollback walks the steps from the last one down
                k    = {~phase, ~j};
                pos  = k ^ BYTE_SWAP;
                o    = c.even;
                e    = c.odd;
                r    = nlf(o);
                e_sh = {1'b0, e[HALF_W-1:1]};
                nb   = (r & fb) ^ e[0] ^ (^(e_sh & POLY_EVEN)) ^ (^(o & POLY_ODD))
                       ^ word[pos];
                c.odd  = o;
                c.even = {nb, e[HALF_W-1:1]};
            end else begin
                k    = {phase, j};
                pos  = k ^ BYTE_SWAP;
                o    = c.odd;
                e    = c.even;
                r    = nlf(o);
                e_sh = e;
                nb   = (r & fb) ^ (^(e_sh & POLY_EVEN)) ^ (^(o & POLY_ODD)) ^ word[pos];
                c.odd  = {e[HALF_W-2:0], nb};
                c.even = o;
            end
            c.ks[pos] = r;
        end
        return c;
    endfunction

endpackage

[rtl/c1sc_front.sv]
// Front end: input queue that accepts items and decodes the action field.
// Depends on c1sc_pkg.
module c1sc_front #(
    parameter int unsigned DEPTH = c1sc_pkg::DEF_CMD_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [c1sc_pkg::ACT_W-1:0]  action,
    input  logic [c1sc_pkg::WORD_W-1:0] data_word,
    input  logic                         feedback_enable,
    input  logic [c1sc_pkg::KEY_W-1:0]  key_value,
    output logic                         cmd_valid,
    output c1sc_pkg::cmd_t               cmd,
    input  logic                         cmd_take
);
    import c1sc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             decoded;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        decoded.load       = 1'b0;
        decoded.word_op    = 1'b0;
        decoded.back       = 1'b0;
        decoded.last_phase = '0;
        decoded.word       = data_word;
        decoded.fb         = feedback_enable;
        decoded.key        = key_value;
        unique case (action)
            ACT_LOAD:
            begin
                decoded.load = 1'b1;
            end
            ACT_CRYPT:
            begin
                decoded.word_op    = 1'b1;
                decoded.last_phase = PHASE_W'(WORD_CHUNKS - 1);
            end
            ACT_ROLLBACK:
            begin
                decoded.word_op    = 1'b1;
                decoded.back       = 1'b1;
                decoded.last_phase = PHASE_W'(WORD_CHUNKS - 1);
            end
            default:
            begin
                // unused code: report the register, leave it alone
                decoded.load = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[rtl/c1sc_back.sv]
// Back end: cipher register, 8-steps-per-clock engine and result queue.
// Depends on c1sc_pkg; takes decoded commands from c1sc_front.
module c1sc_back #(
    parameter int unsigned RES_DEPTH = c1sc_pkg::DEF_RES_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  c1sc_pkg::cmd_t               cmd,
    output logic                         cmd_take,
    output logic                         empty,
    input  logic                         pop,
    output logic [c1sc_pkg::WORD_W-1:0] keystream_word,
    output logic [c1sc_pkg::KEY_W-1:0]  register_value
);
    import c1sc_pkg::*;

    localparam int unsigned PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

    logic [HALF_W-1:0]  odd_reg, odd_next;
    logic [HALF_W-1:0]  even_reg, even_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [WORD_W-1:0]  ks_reg, ks_next;

    result_t            res_reg [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    chunk_t             chunk;
    halves_t            loaded;
    result_t            res_new;
    logic               last;
    logic               room;
    logic               step_en;
    logic               do_pop;

    assign chunk  = run_chunk(odd_reg, even_reg, cmd.word, cmd.fb, cmd.back, phase_reg);
    assign loaded = key_to_halves(cmd.key);

    assign last     = (phase_reg == cmd.last_phase);
    assign room     = (count_reg != CNT_W'(RES_DEPTH));
    // mid-word chunks need no result slot, only the closing one does
    assign step_en  = cmd_valid && (!last || room);
    assign cmd_take = step_en && last;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        odd_next   = odd_reg;
        even_next  = even_reg;
        ks_next    = '0;
        phase_next = phase_reg;
        if (cmd.load)
        begin
            odd_next  = loaded.odd;
            even_next = loaded.even;
        end
        else if (cmd.word_op)
        begin
            odd_next  = chunk.odd;
            even_next = chunk.even;
            ks_next   = ((phase_reg == '0) ? '0 : ks_reg) | chunk.ks;
        end
        if (step_en)
        begin
            phase_next = last ? '0 : phase_reg + 1'b1;
        end
    end

    assign res_new.ks   = ks_next;
    assign res_new.regv = pack_reg(odd_next, even_next);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd_take)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd_take && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg    <= '0;
            even_reg   <= '0;
            phase_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (step_en)
            begin
                odd_reg  <= odd_next;
                even_reg <= even_next;
            end
            phase_reg  <= phase_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            ks_reg <= ks_next;
        end
        if (cmd_take)
        begin
            res_reg[wr_ptr_reg] <= res_new;
        end
    end

    assign empty          = (count_reg == '0);
    assign keystream_word = res_reg[rd_ptr_reg].ks;
    assign register_value = res_reg[rd_ptr_reg].regv;

endmodule

[rtl/crypto1_stream_cipher_word_core.sv]
// Crypto1 stream cipher word core: top level joining front queue and cipher back end.
// Depends on c1sc_pkg, c1sc_front and c1sc_back.
//
// Usage:
//   Input channel is queue-like: drive action/data_word/feedback_enable/key_value and
//   raise push; the item is taken on a clock edge where push is high and full is low.
//   Result channel: while empty is low, keystream_word/register_value show the oldest
//   result; it is taken on an edge where pop is high and empty is low.
//   Action load puts key_value into the 48-bit register.
//   Crypt and rollback run 32 cipher steps, 8 per clock while the engine is not paused;
//   the 8-step filter/feedback chain of the step unit sets that rate.
//   Unused action code 3 returns the current register with a zero keystream word.
// Throughput: the engine works on one word item at a time; one load per cycle while the
//   result queue has room.
// The front queue (CMD_DEPTH items) keeps taking items while the engine works; the
//   result queue (RES_DEPTH items) lets results wait. If the result queue is full the
//   engine pauses before its last step group, and once the front queue fills, full rises.
// Reset clears the cipher register to zero and empties both queues.
module crypto1_stream_cipher_word_core #(
    parameter int unsigned CMD_DEPTH = c1sc_pkg::DEF_CMD_DEPTH,
    parameter int unsigned RES_DEPTH = c1sc_pkg::DEF_RES_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [c1sc_pkg::ACT_W-1:0]  action,
    input  logic [c1sc_pkg::WORD_W-1:0] data_word,
    input  logic                         feedback_enable,
    input  logic [c1sc_pkg::KEY_W-1:0]  key_value,
    output logic                         empty,
    input  logic                         pop,
    output logic [c1sc_pkg::WORD_W-1:0] keystream_word,
    output logic [c1sc_pkg::KEY_W-1:0]  register_value
);
    import c1sc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    // item intake and action decode
    c1sc_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .data_word       (data_word),
        .feedback_enable (feedback_enable),
        .key_value       (key_value),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_take        (cmd_take)
    );

    // cipher register, step engine and result queue
    c1sc_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .empty          (empty),
        .pop            (pop),
        .keystream_word (keystream_word),
        .register_value (register_value)
    );

endmodule

[rtl/c1sc_checker.sv]
// Port-level checks for the Crypto1 word core, bound onto the top level.
// Depends on c1sc_pkg and crypto1_stream_cipher_word_core.
module c1sc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [c1sc_pkg::WORD_W-1:0] keystream_word,
    input logic [c1sc_pkg::KEY_W-1:0]  register_value
);
    import c1sc_pkg::*;

    // in the cycle after reset is seen low, the result queue is empty and the input queue is not full
    a_reset_queues: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not empty in reset");

    // a waiting result holds still until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(keystream_word) && $stable(register_value))
        else $error("waiting result changed");

    // results leave only by pop
    a_empty_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result vanished without pop");

    // the input queue fills only by push
    a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full without push");

endmodule

bind crypto1_stream_cipher_word_core c1sc_checker u_c1sc_checker (.*);
